// ===== rtl/cclp_pkg.sv =====
`default_nettype none

package cclp_pkg;

    // type byte codes
    localparam logic [7:0] TYPE_COND_MASK = 8'hF8;
    localparam logic [7:0] TYPE_COND      = 8'hD0;
    localparam logic [7:0] TYPE_HI_MASK   = 8'hF0;
    localparam logic [7:0] TYPE_WRITE8    = 8'h80;
    localparam logic [7:0] TYPE_WRITEA    = 8'hA0;
    localparam logic [7:0] TYPE_WRITEF0   = 8'hF0;
    localparam logic [7:0] TYPE_WRITEF1   = 8'hF1;
    localparam logic [7:0] TYPE_EXPANSION = 8'hEE;
    localparam logic [7:0] TYPE_REPEAT    = 8'h50;

    localparam logic [15:0] WORDS_MAX     = 16'hFFFF;
    localparam logic [15:0] WORDS_TAIL    = 16'd4;
    localparam logic [15:0] WORDS_COND    = 16'd4;
    localparam logic [7:0]  WORDS_WRITE   = 8'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_BUDGET      = 2'd0;
    localparam logic [1:0] CFG_EXPANSION   = 2'd1;
    localparam logic [1:0] CFG_REPEAT_FLAT = 2'd2;
    localparam logic [1:0] CFG_REPEAT_INCR = 2'd3;

    typedef enum logic [1:0] {
        PH_START,
        PH_TESTS,
        PH_REPEAT,
        PH_REFUSED
    } t_phase;

    typedef struct packed {
        logic [15:0] budget_words;
        logic [7:0]  expansion_words;
        logic [7:0]  repeat_flat_words;
        logic [7:0]  repeat_incr_words;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] pending_words;
        logic [15:0] total_words;
        logic        total_over;
        logic [15:0] lines_seen;
        logic        any_refused;
        logic        repeat_step_odd;
        logic        repeat_incrementing;
    } t_state;

    typedef struct packed {
        logic        refused;
        logic [15:0] line_count;
        logic        fits;
    } t_result;

    function automatic t_state list_reset_state();
        t_state s;
        s.phase               = PH_START;
        s.pending_words       = '0;
        s.total_words         = WORDS_TAIL;
        s.total_over          = 1'b0;
        s.lines_seen          = '0;
        s.any_refused         = 1'b0;
        s.repeat_step_odd     = 1'b0;
        s.repeat_incrementing = 1'b0;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cclp_cfg_regs.sv =====
`default_nettype none

module cclp_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    output cclp_pkg::t_cfg           o_cfg
);

    cclp_pkg::t_cfg r_cfg;
    cclp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                cclp_pkg::CFG_BUDGET:      n_cfg.budget_words      = i_cfg_data;
                cclp_pkg::CFG_EXPANSION:   n_cfg.expansion_words   = i_cfg_data[7:0];
                cclp_pkg::CFG_REPEAT_FLAT: n_cfg.repeat_flat_words = i_cfg_data[7:0];
                cclp_pkg::CFG_REPEAT_INCR: n_cfg.repeat_incr_words = i_cfg_data[7:0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.budget_words      <= 16'd512;
            r_cfg.expansion_words   <= 8'd4;
            r_cfg.repeat_flat_words <= 8'd8;
            r_cfg.repeat_incr_words <= 8'd10;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/cclp_step.sv =====
`default_nettype none

module cclp_step (
    input  wire cclp_pkg::t_state i_state,
    input  wire cclp_pkg::t_cfg   i_cfg,
    input  wire logic [31:0]   i_addr,
    input  wire logic [31:0]   i_value,
    output logic               o_term,
    output cclp_pkg::t_state   o_state,
    output cclp_pkg::t_result  o_result
);

    logic [7:0]  w_type;
    logic [7:0]  w_hi;
    logic        w_odd;
    logic        w_is_cond;
    logic        w_is_write;
    logic        w_body_write;
    logic        w_close;
    logic        w_refuse;
    logic [7:0]  w_body;
    logic [16:0] w_pend_sum;
    logic [17:0] w_atom_sum;
    logic        w_refused_out;

    assign w_type       = i_addr[31:24];
    assign w_hi         = w_type & cclp_pkg::TYPE_HI_MASK;
    assign w_odd        = w_type[0] & i_addr[0];
    assign w_is_cond    = ((w_type & cclp_pkg::TYPE_COND_MASK) == cclp_pkg::TYPE_COND) && !w_odd;
    assign w_is_write   = (w_hi == cclp_pkg::TYPE_WRITE8) || (w_hi == cclp_pkg::TYPE_WRITEA);
    assign w_body_write = w_is_write || (w_type == cclp_pkg::TYPE_WRITEF0)
                          || (w_type == cclp_pkg::TYPE_WRITEF1);
    assign o_term       = (i_addr == '0) && (i_value == '0);

    assign w_pend_sum = {1'b0, i_state.pending_words} + {1'b0, cclp_pkg::WORDS_COND};
    assign w_atom_sum = {2'b00, i_state.total_words} + {2'b00, i_state.pending_words}
                        + {10'd0, w_body};

    // classify the line against the parse phase
    always_comb begin
        w_close  = 1'b0;
        w_refuse = 1'b0;
        w_body   = '0;
        o_state  = i_state;
        if (o_term) begin
            o_state = cclp_pkg::list_reset_state();
        end else begin
            if (i_state.lines_seen != cclp_pkg::WORDS_MAX) begin
                o_state.lines_seen = i_state.lines_seen + 16'd1;
            end
            unique case (i_state.phase)
                cclp_pkg::PH_START, cclp_pkg::PH_TESTS: begin
                    if (w_is_cond) begin
                        o_state.pending_words = w_pend_sum[16] ? cclp_pkg::WORDS_MAX
                                                               : w_pend_sum[15:0];
                        o_state.phase = cclp_pkg::PH_TESTS;
                    end else if (w_body_write) begin
                        // gs-button bit only matters for 8x/Ax
                        if ((w_type[3] && (w_hi != cclp_pkg::TYPE_HI_MASK)) || w_odd) begin
                            w_refuse = 1'b1;
                        end else begin
                            w_close = 1'b1;
                            w_body  = cclp_pkg::WORDS_WRITE;
                        end
                    end else if (w_type == cclp_pkg::TYPE_EXPANSION) begin
                        w_close = 1'b1;
                        w_body  = i_cfg.expansion_words;
                    end else if (w_type == cclp_pkg::TYPE_REPEAT) begin
                        if (i_addr[15:8] == 8'd0) begin
                            w_refuse = 1'b1;
                        end else begin
                            o_state.repeat_step_odd     = i_addr[0];
                            o_state.repeat_incrementing = (i_value[15:0] != 16'd0);
                            o_state.phase               = cclp_pkg::PH_REPEAT;
                        end
                    end else begin
                        w_refuse = 1'b1;
                    end
                end
                cclp_pkg::PH_REPEAT: begin
                    if (!w_is_write || w_type[3] || w_odd
                        || (w_type[0] && i_state.repeat_step_odd)) begin
                        w_refuse = 1'b1;
                    end else begin
                        w_close = 1'b1;
                        w_body  = i_state.repeat_incrementing ? i_cfg.repeat_incr_words
                                                              : i_cfg.repeat_flat_words;
                    end
                end
                default: begin
                    o_state.phase = cclp_pkg::PH_REFUSED;
                end
            endcase

            // zero-priced bodies cannot be emitted
            if (w_close && (w_body == 8'd0)) begin
                w_refuse = 1'b1;
            end
            if (w_refuse) begin
                o_state.any_refused = 1'b1;
                o_state.phase       = cclp_pkg::PH_REFUSED;
            end else if (w_close) begin
                if (w_atom_sum[17:16] != 2'b00) begin
                    o_state.total_over  = 1'b1;
                    o_state.total_words = cclp_pkg::WORDS_MAX;
                end else begin
                    o_state.total_words = w_atom_sum[15:0];
                end
                o_state.pending_words = '0;
                o_state.phase         = cclp_pkg::PH_START;
            end
        end
    end

    // report built from the state before the terminator
    always_comb begin
        w_refused_out = i_state.any_refused || (i_state.phase == cclp_pkg::PH_TESTS)
                        || (i_state.phase == cclp_pkg::PH_REPEAT);
        o_result.refused    = w_refused_out;
        o_result.line_count = i_state.lines_seen;
        o_result.fits       = (i_state.lines_seen != 16'd0) && !w_refused_out
                              && !i_state.total_over
                              && (i_state.total_words <= i_cfg.budget_words);
    end

endmodule

`default_nettype wire

// ===== rtl/cheat_code_list_pricer_top.sv =====
`default_nettype none

// cheat code list pricer
//
// s_axis carries one code line per transaction: tdata[31:0] is the address word
// (type byte in [31:24]) and tdata[63:32] the value word. a line of two zero
// words is the terminator; it closes the list and produces exactly one report
// transaction on m_axis. other lines produce nothing on m_axis.
// m_axis tdata: [0] fits, [16:1] line_count, [17] refused, [23:18] zero.
// config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 budget,
// 1 expansion price, 2 flat repeater price, 3 incrementing repeater price);
// write only while no line is in flight; the block does not enforce it.
// flow: a line is captured in the input register on acceptance and priced from
// there into the list state; a terminator waits there while a report is held,
// and its report is registered when it is priced. throughput is one line per
// cycle while no terminator waits, set by the single pass through the adder.
// reset: synchronous, active low; clears the list state, the in-flight line
// and the report, and loads the register defaults (512, 4, 8, 10).
// stall: a waiting report holds back the next terminator and the lines behind it;
// ordinary lines ahead of it keep flowing into the list state while m_axis_tready is low.

module cheat_code_list_pricer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // line input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] code_address, [63:32] code_value
    // report output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [0] fits, [16:1] line_count, [17] refused
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    cclp_pkg::t_cfg    w_cfg;
    cclp_pkg::t_state  r_state;
    cclp_pkg::t_state  n_state;
    cclp_pkg::t_result w_result;
    cclp_pkg::t_result r_result;

    logic        r_in_valid;
    logic [31:0] r_addr;
    logic [31:0] r_value;
    logic        r_out_valid;
    logic        w_term;
    logic        w_adv;
    logic        w_in_acc;

    cclp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cclp_step u_step (
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .i_addr   (r_addr),
        .i_value  (r_value),
        .o_term   (w_term),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // a buffered line moves on unless it is a terminator blocked by a held report
    assign w_adv         = r_in_valid && (!w_term || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr  <= s_axis_tdata[31:0];
            r_value <= s_axis_tdata[63:32];
        end
    end

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cclp_pkg::list_reset_state();
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_term) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_term) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_result};

    // a report appears only after a terminator was priced
    a_report_from_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_adv && w_term))
        else $error("report raised without a terminator");

    // the terminator restarts the list
    a_term_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_term) |=> (r_state.lines_seen == 16'd0
                               && r_state.phase == cclp_pkg::PH_START
                               && !r_state.any_refused))
        else $error("list state not restarted after terminator");

    // a refused list never fits
    a_fits_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[17]))
        else $error("report both fits and refused");

    // every priced ordinary line is counted once until the count saturates
    a_line_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_term && r_state.lines_seen != cclp_pkg::WORDS_MAX)
        |=> (r_state.lines_seen == $past(r_state.lines_seen) + 16'd1))
        else $error("line count did not advance");

endmodule

`default_nettype wire

// ===== tb/sv/cheat_code_list_pricer_top_test.sv =====
module cheat_code_list_pricer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cclp_pkg::*;

    // type byte modifiers used to build bad lines
    localparam logic [7:0] GS_BIT   = 8'h08;
    localparam logic [7:0] HALF_BIT = 8'h01;

    localparam int unsigned WATCHDOG_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned LINES_PER_PHASE  = 110;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // [31:0] code_address, [63:32] code_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [0] fits, [16:1] line_count, [17] refused
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_BUDGET;
    logic [15:0] i_cfg_data    = '0;

    // idle percentages for the line sender and the report sink
    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;

    int unsigned lines_driven   = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // reports predicted at terminator acceptance, oldest first
    t_result pending_reports[$];

    // predictor copy of the pricing registers and the list state
    t_cfg        pricing;
    t_phase      parse_state;
    logic [15:0] cond_words;
    logic [15:0] engine_words;
    logic        engine_over;
    logic [15:0] line_tally;
    logic        list_refused;
    logic        rep_step_odd;
    logic        rep_incr;

    cheat_code_list_pricer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // list pricing predictor
    // ---------------------------------------------------------------

    function automatic void restart_list();
        parse_state  = PH_START;
        cond_words   = '0;
        engine_words = WORDS_TAIL;
        engine_over  = 1'b0;
        line_tally   = '0;
        list_refused = 1'b0;
        rep_step_odd = 1'b0;
        rep_incr     = 1'b0;
    endfunction

    // 16-bit access type with an odd address
    function automatic bit odd_half(input logic [31:0] addr);
        return addr[24] && addr[0];
    endfunction

    function automatic void refuse_list();
        list_refused = 1'b1;
        parse_state  = PH_REFUSED;
    endfunction

    // add the open conditionals and the body to the running total; a zero-priced body refuses the list
    function automatic void close_atom(input logic [7:0] body_words);
        int unsigned sum;
        if (body_words == 0) begin
            refuse_list();
        end else begin
            sum = engine_words + cond_words + body_words;
            if (sum > WORDS_MAX) begin
                engine_over = 1'b1;
                sum = WORDS_MAX;
            end
            engine_words = 16'(sum);
            cond_words   = '0;
            parse_state  = PH_START;
        end
    endfunction

    function automatic void price_line(input logic [31:0] addr, input logic [31:0] data,
                                       output bit has_report, output t_result report);
        logic [7:0] kind;
        logic [7:0] hi;
        kind = addr[31:24];
        hi = kind & TYPE_HI_MASK;
        has_report = 1'b0;
        report = '0;
        if (addr == '0 && data == '0) begin
            // terminator: an atom still open counts as a refusal
            if (parse_state == PH_TESTS || parse_state == PH_REPEAT)
                list_refused = 1'b1;
            report.fits = line_tally != 0 && !list_refused && !engine_over
                          && engine_words <= pricing.budget_words;
            report.line_count = line_tally;
            report.refused = list_refused;
            has_report = 1'b1;
            restart_list();
        end else begin
            if (line_tally != WORDS_MAX)
                line_tally = line_tally + 1'b1;
            case (parse_state)
                PH_START, PH_TESTS: begin
                    if ((kind & TYPE_COND_MASK) == TYPE_COND && !odd_half(addr)) begin
                        cond_words = (cond_words > WORDS_MAX - WORDS_COND) ? WORDS_MAX
                                     : cond_words + WORDS_COND;
                        parse_state = PH_TESTS;
                    end else if (hi == TYPE_WRITE8 || hi == TYPE_WRITEA
                                 || kind == TYPE_WRITEF0 || kind == TYPE_WRITEF1) begin
                        // gs button bit only matters on 8x/Ax writes
                        if ((kind & GS_BIT) != 0 && hi != TYPE_WRITEF0)
                            refuse_list();
                        else if (odd_half(addr))
                            refuse_list();
                        else
                            close_atom(WORDS_WRITE);
                    end else if (kind == TYPE_EXPANSION) begin
                        close_atom(pricing.expansion_words);
                    end else if (kind == TYPE_REPEAT) begin
                        if (addr[15:8] == 0) begin
                            refuse_list();
                        end else begin
                            rep_step_odd = addr[0];
                            rep_incr = data[15:0] != 0;
                            parse_state = PH_REPEAT;
                        end
                    end else begin
                        refuse_list();
                    end
                end
                PH_REPEAT: begin
                    // repeater target must be an aligned 8x/Ax write without the gs button bit
                    if (!(hi == TYPE_WRITE8 || hi == TYPE_WRITEA) || (kind & GS_BIT) != 0
                        || odd_half(addr) || (kind[0] && rep_step_odd))
                        refuse_list();
                    else
                        close_atom(rep_incr ? pricing.repeat_incr_words
                                            : pricing.repeat_flat_words);
                end
                default: ;  // refused: lines are only counted
            endcase
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus plumbing
    // ---------------------------------------------------------------

    // one code line transaction; prediction happens at the accepting edge
    task automatic send_line(input logic [31:0] addr, input logic [31:0] data);
        bit      got;
        t_result report;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        price_line(addr, data, got, report);
        if (got)
            pending_reports.push_back(report);
        lines_driven++;
    endtask

    // hold off new lines until every report is back and the pipe is empty
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_pricing(input logic [15:0] budget, input logic [7:0] expansion,
                                   input logic [7:0] flat, input logic [7:0] incr);
        logic [1:0]  reg_index[4];
        logic [15:0] reg_value[4];
        reg_index = '{CFG_BUDGET, CFG_EXPANSION, CFG_REPEAT_FLAT, CFG_REPEAT_INCR};
        reg_value = '{budget, 16'(expansion), 16'(flat), 16'(incr)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_index[k];
            i_cfg_data  <= reg_value[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        pricing.budget_words      = budget;
        pricing.expansion_words   = expansion;
        pricing.repeat_flat_words = flat;
        pricing.repeat_incr_words = incr;
    endtask

    function automatic logic [31:0] write_address(input bit with_f);
        logic [31:0] addr;
        addr = $urandom();
        case ($urandom_range(with_f ? 3 : 1, 0))
            0:       addr[31:24] = TYPE_WRITE8 | 8'($urandom_range(7, 0));
            1:       addr[31:24] = TYPE_WRITEA | 8'($urandom_range(7, 0));
            2:       addr[31:24] = TYPE_WRITEF0;
            default: addr[31:24] = TYPE_WRITEF1;
        endcase
        if (addr[24])
            addr[0] = 1'b0;
        return addr;
    endfunction

    // one atom: optional conditionals then a body; broken atoms carry at most one fault
    task automatic send_atom(input bit broken);
        int unsigned n_cond;
        int unsigned fault;
        int unsigned target_flaw;
        logic [31:0] line;
        logic [31:0] target;
        logic [31:0] data;
        n_cond = ($urandom_range(2, 0) == 0) ? $urandom_range(3, 1) : 0;
        fault = broken ? $urandom_range(4, 0) : 5;
        target_flaw = $urandom_range(2, 0);
        for (int k = 0; k < n_cond; k++) begin
            line = $urandom();
            line[31:24] = TYPE_COND | 8'($urandom_range(7, 0));
            if (line[24])
                line[0] = 1'b0;
            if (fault == 0 && k == n_cond - 1) begin
                line[24] = 1'b1;
                line[0]  = 1'b1;
            end
            send_line(line, $urandom());
        end
        // atom left open before the terminator or the next atom
        if (fault == 1 && n_cond != 0)
            return;
        case ($urandom_range(2, 0))
            0: begin
                line = write_address(1'b1);
                if (fault == 2 && line[31:28] != TYPE_WRITEF0[7:4])
                    line[31:24] = line[31:24] | GS_BIT;
                if (fault == 3) begin
                    line[24] = 1'b1;
                    line[0]  = 1'b1;
                end
                send_line(line, $urandom());
            end
            1: begin
                line = $urandom();
                line[31:24] = TYPE_EXPANSION;
                send_line(line, $urandom());
            end
            default: begin
                line = $urandom();
                line[31:24] = TYPE_REPEAT;
                if (line[15:8] == 0)
                    line[15:8] = 8'd1;
                if (fault == 2)
                    line[15:8] = 8'd0;
                if (fault == 4 && target_flaw == 2)
                    line[0] = 1'b1;
                data = $urandom();
                if ($urandom_range(1, 0) == 0)
                    data[15:0] = '0;
                send_line(line, data);
                if (fault == 1)
                    return;
                target = write_address(1'b0);
                if (line[0])
                    target[24] = 1'b0;
                if (fault == 3)
                    target[31:24] = ($urandom_range(1, 0) == 0) ? TYPE_EXPANSION
                                                                : TYPE_WRITEF0;
                if (fault == 4) begin
                    case (target_flaw)
                        0: target[31:24] = target[31:24] | GS_BIT;
                        1: begin
                            target[24] = 1'b1;
                            target[0]  = 1'b1;
                        end
                        default: begin
                            // odd step into a 16-bit target
                            target[24] = 1'b1;
                            target[0]  = 1'b0;
                        end
                    endcase
                end
                send_line(target, $urandom());
            end
        endcase
    endtask

    task automatic send_random_list();
        int unsigned n_atoms;
        n_atoms = $urandom_range(4, 0);
        repeat (n_atoms) begin
            if ($urandom_range(9, 0) == 0)
                send_line($urandom(), $urandom());
            else
                send_atom($urandom_range(7, 0) == 0);
        end
        send_line('0, '0);
    endtask

    function automatic logic [7:0] pick_price();
        case ($urandom_range(9, 0))
            0:       return 8'd0;
            1:       return 8'hFF;
            default: return 8'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_budget();
        case ($urandom_range(9, 0))
            0:       return 16'd0;
            1:       return WORDS_MAX;
            default: return 16'($urandom_range(200, 4));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // short lists at the reset pricing covering each body and refusal
    task automatic test_directed_lists();
        send_idle_pct  = 13;
        sink_stall_pct = 13;
        // empty list
        send_line('0, '0);
        // every body kind, all accepted
        send_line({TYPE_WRITE8, 24'h123456}, 32'hFFFF_FFFF);
        send_line({TYPE_WRITEA | HALF_BIT, 24'h000002}, 32'h0000_FFFF);
        send_line({TYPE_WRITEF0, 24'hFFFFFF}, 32'h0);
        send_line({TYPE_WRITEF1, 24'hFFFFFE}, 32'h1);
        send_line({TYPE_EXPANSION, 24'h0}, 32'h0);
        send_line({TYPE_REPEAT, 24'h000102}, 32'h1234_0001);
        send_line({TYPE_WRITE8, 24'h000010}, 32'h0);
        send_line('0, '0);
        // conditionals then a repeater with odd step into a 16-bit target
        send_line({TYPE_COND, 24'h0}, 32'h0);
        send_line({TYPE_COND | 8'h07, 24'h000002}, 32'h5);
        send_line({TYPE_REPEAT, 24'h000203}, 32'h0001_0000);
        send_line({TYPE_WRITEA | HALF_BIT, 24'h000010}, 32'h0);
        send_line({TYPE_WRITE8, 24'h0}, 32'h0);
        send_line('0, '0);
        // gs button write
        send_line({TYPE_WRITE8 | GS_BIT, 24'h0}, 32'h0);
        send_line('0, '0);
        // odd 16-bit write address
        send_line({TYPE_WRITEA | HALF_BIT, 24'h000001}, 32'h0);
        send_line('0, '0);
        // odd conditional becomes a refused body
        send_line({TYPE_COND | HALF_BIT, 24'h000001}, 32'h0);
        send_line('0, '0);
        // repeater with zero count
        send_line({TYPE_REPEAT, 24'h0}, 32'h1);
        send_line('0, '0);
        // repeater whose target is not a write
        send_line({TYPE_REPEAT, 24'h000100}, 32'h1);
        send_line({TYPE_EXPANSION, 24'h0}, 32'h0);
        send_line('0, '0);
        // conditional run still open at the terminator
        send_line({TYPE_COND, 24'h0}, 32'h0);
        send_line('0, '0);
        // all ones is an unknown type
        send_line(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_line('0, '0);
        drain_reports();
    endtask

    // zero prices refuse, full prices and budget boundaries
    task automatic test_price_extremes();
        program_pricing(16'd0, 8'd0, 8'd0, 8'hFF);
        send_line({TYPE_EXPANSION, 24'h0}, 32'h0);
        send_line('0, '0);
        send_line({TYPE_REPEAT, 24'h000100}, 32'h0);
        send_line({TYPE_WRITE8, 24'h0}, 32'h0);
        send_line('0, '0);
        send_line({TYPE_REPEAT, 24'h000100}, 32'h1);
        send_line({TYPE_WRITE8, 24'h0}, 32'h0);
        send_line('0, '0);
        drain_reports();
        program_pricing(WORDS_MAX, 8'hFF, 8'hFF, 8'd0);
        send_line({TYPE_REPEAT, 24'h000100}, 32'h1);
        send_line({TYPE_WRITE8, 24'h0}, 32'h0);
        send_line('0, '0);
        send_line({TYPE_EXPANSION, 24'h0}, 32'h0);
        send_line({TYPE_REPEAT, 24'hFFFFFE}, 32'hFFFF_0000);
        send_line({TYPE_WRITEA | 8'h02, 24'h0}, 32'h0);
        send_line('0, '0);
        drain_reports();
        // total of 7 words exactly on and just over the budget
        for (int b = 7; b >= 6; b--) begin
            program_pricing(16'(b), 8'd1, 8'd1, 8'd1);
            send_line({TYPE_WRITE8, 24'h0}, 32'h0);
            send_line('0, '0);
            drain_reports();
        end
    endtask

    // random lists under each idling mix, new pricing per phase
    task automatic test_random_lists();
        int unsigned idle_plan[4][2];
        int unsigned first;
        idle_plan = '{'{0, 0}, '{64, 0}, '{0, 64}, '{13, 13}};
        for (int ph = 0; ph < 4; ph++) begin
            drain_reports();
            program_pricing(pick_budget(), pick_price(), pick_price(), pick_price());
            send_idle_pct  = idle_plan[ph][0];
            sink_stall_pct = idle_plan[ph][1];
            first = lines_driven;
            while (lines_driven - first < LINES_PER_PHASE)
                send_random_list();
        end
        drain_reports();
    endtask

    // ---------------------------------------------------------------
    // report checker, sink stalls and watchdog
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : report_check
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = t_result'(m_axis_tdata[17:0]);
            if (pending_reports.size() == 0) begin
                $error("report transaction with nothing expected: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (seen.fits !== want.fits) begin
                    $error("fits: expected %0d, actual %0d", want.fits, seen.fits);
                    mismatch_count++;
                end
                if (seen.line_count !== want.line_count) begin
                    $error("line_count: expected %0d, actual %0d",
                           want.line_count, seen.line_count);
                    mismatch_count++;
                end
                if (seen.refused !== want.refused) begin
                    $error("refused: expected %0d, actual %0d", want.refused, seen.refused);
                    mismatch_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
        // no transaction on either side for too long means a hang
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        restart_list();
        pricing = '{budget_words: 16'd512, expansion_words: 8'd4,
                    repeat_flat_words: 8'd8, repeat_incr_words: 8'd10};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_lists();
        test_price_extremes();
        test_random_lists();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cclp_pkg.sv
rtl/cclp_cfg_regs.sv
rtl/cclp_step.sv
rtl/cheat_code_list_pricer_top.sv
tb/sv/cheat_code_list_pricer_top_test.sv
